// ===== rtl/core/lat_pkg.sv =====
// Package for the load average tracker: field widths, register indexes
// and reset values shared by the core and its helper modules.
// No dependencies.
package lat_pkg;

    localparam int COUNT_W  = 8;
    localparam int PERIOD_W = 16;
    localparam int DECAY_W  = 12;
    localparam int LOAD_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOAD_PERIOD = 2'd0,
        REG_DECAY_SHORT = 2'd1,
        REG_DECAY_MID   = 2'd2,
        REG_DECAY_LONG  = 2'd3
    } cfg_reg_t;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET      = 16'd500;
    localparam logic [DECAY_W-1:0]  DECAY_SHORT_RESET = 12'd1884;
    localparam logic [DECAY_W-1:0]  DECAY_MID_RESET   = 12'd2014;
    localparam logic [DECAY_W-1:0]  DECAY_LONG_RESET  = 12'd2037;

    localparam int HUNDRED = 100;

endpackage

// ===== rtl/core/lat_ewma.sv =====
// One exponential moving average register with its update datapath.
// Depends on lat_pkg.
module lat_ewma #(
    parameter int FRAC_BITS = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                upd_en,
    input  logic [lat_pkg::DECAY_W-1:0]         decay,
    input  logic [lat_pkg::COUNT_W-1:0]         count,
    output logic [lat_pkg::COUNT_W+FRAC_BITS-1:0] avg
);
    import lat_pkg::*;

    localparam int AVG_W  = COUNT_W + FRAC_BITS;
    localparam int CMP_W  = (DECAY_W > FRAC_BITS + 1) ? DECAY_W : FRAC_BITS + 1;
    localparam int PROD_W = AVG_W + CMP_W + 2;

    logic [AVG_W-1:0]         avg_reg;
    logic [AVG_W-1:0]         avg_next;
    logic [CMP_W-1:0]         one_ext;
    logic [CMP_W-1:0]         decay_ext;
    logic [CMP_W-1:0]         decay_clamp;
    logic [CMP_W-1:0]         one_minus_d;
    logic [AVG_W-1:0]         sample;
    logic signed [AVG_W:0]    diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] step;

    // avg*d + s*(1-d) equals avg*1 + (s-avg)*(1-d), so the floor of the
    // shifted sum is avg plus the arithmetically shifted difference term.
    always_comb begin
        one_ext     = CMP_W'(1) << FRAC_BITS;
        decay_ext   = CMP_W'(decay);
        decay_clamp = (decay_ext > one_ext) ? one_ext : decay_ext;
        one_minus_d = one_ext - decay_clamp;
        sample      = {count, {FRAC_BITS{1'b0}}};
        diff        = $signed({1'b0, sample}) - $signed({1'b0, avg_reg});
        prod        = PROD_W'(diff) * $signed({1'b0, one_minus_d});
        step        = prod >>> FRAC_BITS;
        avg_next    = avg_reg + step[AVG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
        end else if (upd_en) begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

// ===== rtl/core/lat_scale.sv =====
// Converts a fixed-point average into hundredths with rounding.
// Depends on lat_pkg.
module lat_scale #(
    parameter int FRAC_BITS = 11
) (
    input  logic [lat_pkg::COUNT_W+FRAC_BITS-1:0] avg,
    output logic [lat_pkg::LOAD_W-1:0]            load
);
    import lat_pkg::*;

    localparam int AVG_W   = COUNT_W + FRAC_BITS;
    localparam int SUM_W   = AVG_W + 1;
    localparam int MUL_W   = SUM_W + 7;
    localparam int ROUND_C = (1 << FRAC_BITS) / 200;

    logic [SUM_W-1:0] rounded;
    logic [MUL_W-1:0] scaled;

    always_comb begin
        rounded = SUM_W'(avg) + SUM_W'(ROUND_C);
        scaled  = MUL_W'(rounded) * MUL_W'(HUNDRED);
        load    = scaled[FRAC_BITS +: LOAD_W];
    end

endmodule

// ===== rtl/core/load_average_tracker.sv =====
// Top level of the load average tracker: configuration registers, tick
// countdown and a three-stage pipeline. Depends on lat_pkg, lat_ewma, lat_scale.
//
//  Channel  | Ports                      | Payload
//  ---------+----------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata  | tdata: active_count; tuser: tick
//  result   | m_tvalid m_tready m_tdata  | tdata: short, mid, long; tuser: upd
//  config   | cfg_we cfg_index cfg_wdata | one register per write
//
// One item per cycle unless a stalled result holds the pipeline.
// The input register updates the countdown and the averages, a middle stage
// carries the updated flag, and the result register holds the hundredths.
// Reset is synchronous and active low; there is no clearing pass.
// A stalled result freezes the pipeline, but the input register still takes
// a transfer while it is empty.
module load_average_tracker #(
    parameter int FRAC_BITS = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lat_pkg::S_DATA_W-1:0]      s_tdata,   // [7:0] active_count
    input  logic                              s_tuser,   // [0] kernel_tick
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [14:0] load_short, [29:15] load_mid, [44:30] load_long, [47:45] zero
    output logic [lat_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tuser,   // [0] updated
    input  logic                              cfg_we,
    input  logic [lat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lat_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import lat_pkg::*;

    localparam int AVG_W = COUNT_W + FRAC_BITS;

    logic [PERIOD_W-1:0] period_reg;
    logic [DECAY_W-1:0]  decay_short_reg;
    logic [DECAY_W-1:0]  decay_mid_reg;
    logic [DECAY_W-1:0]  decay_long_reg;
    logic [PERIOD_W-1:0] countdown_reg;
    logic [PERIOD_W-1:0] countdown_next;

    logic                v0_reg;
    logic                tick0_reg;
    logic [COUNT_W-1:0]  count0_reg;
    logic                v1_reg;
    logic                upd1_reg;
    logic                v2_reg;
    logic                upd2_reg;
    logic [LOAD_W-1:0]   short2_reg;
    logic [LOAD_W-1:0]   mid2_reg;
    logic [LOAD_W-1:0]   long2_reg;

    logic                advance;
    logic                tick_fire;
    logic                do_update;
    logic [AVG_W-1:0]    avg_short;
    logic [AVG_W-1:0]    avg_mid;
    logic [AVG_W-1:0]    avg_long;
    logic [LOAD_W-1:0]   load_short;
    logic [LOAD_W-1:0]   load_mid;
    logic [LOAD_W-1:0]   load_long;

    assign advance   = !v2_reg || m_tready;
    assign s_tready  = advance || !v0_reg;
    assign tick_fire = advance && v0_reg && tick0_reg;
    // The countdown reloads on the tick that would take it below zero.
    assign do_update = tick_fire && (countdown_reg == '0);

    always_comb begin
        countdown_next = countdown_reg;
        if (tick_fire) begin
            countdown_next = do_update ? period_reg : countdown_reg - PERIOD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= PERIOD_RESET;
            decay_short_reg <= DECAY_SHORT_RESET;
            decay_mid_reg   <= DECAY_MID_RESET;
            decay_long_reg  <= DECAY_LONG_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_LOAD_PERIOD: period_reg      <= cfg_wdata[PERIOD_W-1:0];
                REG_DECAY_SHORT: decay_short_reg <= cfg_wdata[DECAY_W-1:0];
                REG_DECAY_MID:   decay_mid_reg   <= cfg_wdata[DECAY_W-1:0];
                REG_DECAY_LONG:  decay_long_reg  <= cfg_wdata[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= PERIOD_RESET;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            countdown_reg <= countdown_next;
            if (s_tready) begin
                v0_reg <= s_tvalid;
            end
            if (advance) begin
                v1_reg <= v0_reg;
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            tick0_reg  <= s_tuser;
            count0_reg <= s_tdata[COUNT_W-1:0];
        end
        if (advance) begin
            upd1_reg   <= do_update;
            upd2_reg   <= upd1_reg;
            short2_reg <= load_short;
            mid2_reg   <= load_mid;
            long2_reg  <= load_long;
        end
    end

    lat_ewma #(.FRAC_BITS(FRAC_BITS)) u_ewma_short (
        .aclk(aclk), .aresetn(aresetn), .upd_en(do_update),
        .decay(decay_short_reg), .count(count0_reg), .avg(avg_short)
    );
    lat_ewma #(.FRAC_BITS(FRAC_BITS)) u_ewma_mid (
        .aclk(aclk), .aresetn(aresetn), .upd_en(do_update),
        .decay(decay_mid_reg), .count(count0_reg), .avg(avg_mid)
    );
    lat_ewma #(.FRAC_BITS(FRAC_BITS)) u_ewma_long (
        .aclk(aclk), .aresetn(aresetn), .upd_en(do_update),
        .decay(decay_long_reg), .count(count0_reg), .avg(avg_long)
    );

    // The middle stage reads the averages after the average registers have taken its own update.
    lat_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_short (.avg(avg_short), .load(load_short));
    lat_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_mid   (.avg(avg_mid),   .load(load_mid));
    lat_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_long  (.avg(avg_long),  .load(load_long));

    assign m_tvalid = v2_reg;
    assign m_tuser  = upd2_reg;
    assign m_tdata  = {(M_DATA_W - 3*LOAD_W)'(0), long2_reg, mid2_reg, short2_reg};

endmodule
